### sv/wfg_pkg.sv
package wfg_pkg;

  localparam int SINE_STEPS = 256;
  localparam int HOLD_WIDTH = 24;

  localparam int MODE_W = 3;
  localparam int HOLD_US_W = 24;
  localparam int CFG_IDX_W = 1;
  localparam int SAMPLE_W = 8;
  localparam int SEG_W = 4;
  localparam int SIN_AW = $clog2(SINE_STEPS);
  localparam int IDX_W = (SIN_AW > 9) ? SIN_AW : 9;
  localparam int LEN_W = IDX_W + 1;
  localparam int ECG_SEGS = 9;
  localparam int ECG_TAB_N = 128;
  localparam int ECG_AW = $clog2(ECG_TAB_N);

  localparam int SINE_DEN = SINE_STEPS - 1;
  localparam int ECG_DEN = 255;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam logic [31:0] HOLD_MAX = 32'((64'd1 << HOLD_WIDTH) - 64'd1);

  typedef enum logic [MODE_W-1:0] {
    MODE_SQUARE   = 3'd0,
    MODE_SAWTOOTH = 3'd1,
    MODE_TRIANGLE = 3'd2,
    MODE_SINE     = 3'd3,
    MODE_HALF     = 3'd4,
    MODE_ECG      = 3'd5
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE = 1'b0,
    REG_HOLD = 1'b1
  } cfg_reg_t;

  typedef enum logic [SEG_W-1:0] {
    SEG_P      = 4'd0,
    SEG_PR     = 4'd1,
    SEG_Q      = 4'd2,
    SEG_R_UP   = 4'd3,
    SEG_R_DOWN = 4'd4,
    SEG_S      = 4'd5,
    SEG_ST     = 4'd6,
    SEG_T      = 4'd7,
    SEG_REST   = 4'd8
  } ecg_seg_t;

  typedef struct packed {
    logic [SEG_W-1:0]      segment;
    logic [IDX_W-1:0]      step_index;
    logic [HOLD_WIDTH-1:0] hold_left;
  } wfg_state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                cycle_start;
  } wfg_result_t;

  typedef logic [SAMPLE_W-1:0] sine_tab_t [SINE_STEPS];
  typedef logic [SAMPLE_W-1:0] ecg_tab_t [ECG_TAB_N];
  typedef logic [8:0] ecg_len_t [ECG_SEGS];
  typedef logic [HOLD_WIDTH-1:0] ecg_hold_t [ECG_SEGS];

  localparam ecg_len_t ECG_LEN = '{9'd128, 9'd1, 9'd32, 9'd224, 9'd256,
                                   9'd64, 9'd1, 9'd128, 9'd1};

  // Hold length minus one, clamped to the counter range.
  function automatic logic [HOLD_WIDTH-1:0] sat_hold_m1(input logic [31:0] d_in);
    logic [31:0] d;
    logic [31:0] dm1;
    d = d_in;
    if (d == 32'd0) d = 32'd1;
    if (d > HOLD_MAX) d = HOLD_MAX;
    dm1 = d - 32'd1;
    return dm1[HOLD_WIDTH-1:0];
  endfunction

  function automatic ecg_hold_t build_ecg_hold();
    ecg_hold_t h;
    h[0] = sat_hold_m1(32'd650);
    h[1] = sat_hold_m1(32'd75000);
    h[2] = sat_hold_m1(32'd800);
    h[3] = sat_hold_m1(32'd100);
    h[4] = sat_hold_m1(32'd100);
    h[5] = sat_hold_m1(32'd500);
    h[6] = sat_hold_m1(32'd80000);
    h[7] = sat_hold_m1(32'd1500);
    h[8] = sat_hold_m1(32'd400000);
    return h;
  endfunction

  localparam ecg_hold_t ECG_HOLD_M1 = build_ecg_hold();

  // Angles at multiples of pi/6 with a rational sine get exact values.
  // All ones marks an angle with no exact value.
  function automatic logic [7:0] exact_value(input longint unsigned q);
    logic [7:0] v;
    case (q)
      64'd0, 64'd6:  v = 8'd64;
      64'd1, 64'd5:  v = 8'd96;
      64'd3:         v = 8'd128;
      64'd7, 64'd11: v = 8'd32;
      64'd9:         v = 8'd0;
      default:       v = 8'hFF;
    endcase
    return v;
  endfunction

  // Fixed point Q30 sine, Taylor series to the x^17 term.
  function automatic logic [7:0] sine_of_angle(input longint unsigned ang_in);
    longint unsigned ang;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned k;
    longint sum;
    logic neg;
    logic [31:0] s;
    ang = ang_in;
    neg = (ang >= PI_Q30);
    if (neg) ang = ang - PI_Q30;
    if (ang > HALF_PI_Q30) ang = PI_Q30 - ang;
    x = ang;
    x2 = (x * x) >> 30;
    sum = longint'(x);
    t = x;
    t = ((t * x2) >> 30) / 6;   sum = sum - longint'(t);
    t = ((t * x2) >> 30) / 20;  sum = sum + longint'(t);
    t = ((t * x2) >> 30) / 42;  sum = sum - longint'(t);
    t = ((t * x2) >> 30) / 72;  sum = sum + longint'(t);
    t = ((t * x2) >> 30) / 110; sum = sum - longint'(t);
    t = ((t * x2) >> 30) / 156; sum = sum + longint'(t);
    t = ((t * x2) >> 30) / 210; sum = sum - longint'(t);
    t = ((t * x2) >> 30) / 272; sum = sum + longint'(t);
    if (sum < 0) sum = 0;
    if (sum > 64'sd1073741823) sum = 64'sd1073741823;
    s = 32'(sum);
    if (!neg) return 8'(32'd64 + (s >> 24));
    k = (longint'(s) + 64'd16777215) >> 24;
    return (k >= 64'd64) ? 8'd0 : 8'(64'd64 - k);
  endfunction

  function automatic logic [7:0] sine_entry(input longint unsigned n_in);
    longint unsigned n;
    longint unsigned m;
    logic [7:0] ex;
    n = n_in % SINE_DEN;
    m = 64'd12 * n;
    ex = exact_value(m / SINE_DEN);
    if ((m % SINE_DEN) == 0 && ex != 8'hFF) return ex;
    return sine_of_angle((64'd2 * PI_Q30 * n) / SINE_DEN);
  endfunction

  function automatic logic [7:0] ecg_entry(input longint unsigned n_in);
    longint unsigned n;
    longint unsigned m;
    logic [7:0] ex;
    n = n_in % ECG_DEN;
    m = 64'd12 * n;
    ex = exact_value(m / ECG_DEN);
    if ((m % ECG_DEN) == 0 && ex != 8'hFF) return ex;
    return sine_of_angle((64'd2 * PI_Q30 * n) / ECG_DEN);
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int n = 0; n < SINE_STEPS; n++) begin
      tab[n] = sine_entry(longint'(n));
    end
    return tab;
  endfunction

  function automatic ecg_tab_t build_ecg_tab();
    ecg_tab_t tab;
    for (int n = 0; n < ECG_TAB_N; n++) begin
      tab[n] = ecg_entry(longint'(n));
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();
  localparam ecg_tab_t ECG_TAB = build_ecg_tab();

endpackage

### sv/wfg_step.sv
module wfg_step (
  input  logic [wfg_pkg::MODE_W-1:0]     mode,
  input  logic [wfg_pkg::HOLD_US_W-1:0]  hold_us,
  input  logic                           restart,
  input  wfg_pkg::wfg_state_t            cur,
  output wfg_pkg::wfg_state_t            nxt,
  output logic                           emit,
  output wfg_pkg::wfg_result_t           res
);
  import wfg_pkg::*;

  logic [SEG_W-1:0]      seg;
  logic [IDX_W-1:0]      idx;
  logic [HOLD_WIDTH-1:0] hold;
  logic [LEN_W-1:0]      len;
  logic [IDX_W-1:0]      i;
  logic [LEN_W-1:0]      idx_inc;
  logic [SAMPLE_W-1:0]   val;
  logic [SAMPLE_W-1:0]   ecg_rom;
  logic                  ecg_emit;
  logic                  is_ecg;

  assign is_ecg = (mode == MODE_ECG);

  always_comb begin
    seg  = cur.segment;
    idx  = cur.step_index;
    hold = cur.hold_left;
    if (restart) begin
      seg  = '0;
      idx  = '0;
      hold = '0;
    end
    if (is_ecg && seg >= SEG_W'(ECG_SEGS)) begin
      seg = '0;
      idx = '0;
    end
  end

  always_comb begin
    if (is_ecg) begin
      len = LEN_W'(ECG_LEN[seg]);
    end else begin
      case (mode)
        MODE_SAWTOOTH: len = LEN_W'(256);
        MODE_TRIANGLE: len = LEN_W'(512);
        MODE_SINE:     len = LEN_W'(SINE_STEPS);
        MODE_HALF:     len = LEN_W'(SINE_STEPS / 2);
        default:       len = LEN_W'(2);
      endcase
    end
  end

  assign i       = ({1'b0, idx} >= len) ? '0 : idx;
  assign idx_inc = {1'b0, i} + LEN_W'(1);
  assign ecg_rom = ECG_TAB[i[ECG_AW-1:0]];

  always_comb begin
    ecg_emit = 1'b1;
    case (seg)
      SEG_P:      val = (ecg_rom >> 1) + 8'd32;
      SEG_Q:      val = 8'd64 - i[SAMPLE_W-1:0];
      SEG_R_UP:   val = 8'd32 + i[SAMPLE_W-1:0];
      SEG_R_DOWN: val = 8'd255 - i[SAMPLE_W-1:0];
      SEG_S:      val = i[SAMPLE_W-1:0];
      SEG_T:      val = ecg_rom;
      default: begin
        // The silent gaps only run their hold time.
        val = '0;
        ecg_emit = 1'b0;
      end
    endcase
    if (!is_ecg) begin
      case (mode)
        MODE_SAWTOOTH: val = ~i[SAMPLE_W-1:0];
        MODE_TRIANGLE: val = i[8] ? i[SAMPLE_W-1:0] : ~i[SAMPLE_W-1:0];
        MODE_SINE,
        MODE_HALF:     val = SINE_TAB[i[SIN_AW-1:0]];
        default:       val = (i == '0) ? 8'd255 : 8'd0;
      endcase
    end
  end

  always_comb begin
    nxt = cur;
    nxt.segment = seg;
    nxt.step_index = idx;
    emit = 1'b0;
    res.sample = val;
    res.cycle_start = 1'b0;
    if (hold != '0) begin
      nxt.hold_left = hold - HOLD_WIDTH'(1);
    end else if (is_ecg) begin
      emit = ecg_emit;
      res.cycle_start = (seg == SEG_P) && (i == '0);
      nxt.hold_left = ECG_HOLD_M1[seg];
      if (idx_inc >= len) begin
        nxt.step_index = '0;
        nxt.segment = (seg == SEG_REST) ? SEG_P : seg + SEG_W'(1);
      end else begin
        nxt.step_index = idx_inc[IDX_W-1:0];
      end
    end else begin
      emit = 1'b1;
      res.cycle_start = (i == '0);
      nxt.hold_left = sat_hold_m1({8'd0, hold_us});
      nxt.step_index = (idx_inc >= len) ? '0 : idx_inc[IDX_W-1:0];
    end
  end

endmodule

### sv/wfg_outbuf.sv
module wfg_outbuf (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  wfg_pkg::wfg_result_t         res,
  output logic                         can_load,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [wfg_pkg::SAMPLE_W-1:0] out_sample,
  output logic                         out_cycle_start
);
  import wfg_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  wfg_result_t data_r;

  // The register may refill in the same cycle its word is taken.
  assign can_load = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_valid       = valid_r;
  assign out_sample      = data_r.sample;
  assign out_cycle_start = data_r.cycle_start;

endmodule

### sv/multi_mode_waveform_generator.sv
// Waveform generator driven by a one-microsecond tick word per input. The block
// accepts one tick in every clock cycle while in_stall is low; a result word is
// registered through an input register, then the step logic into the result
// register. Ticks that only count down a hold give no result. The rate is set
// only by back-pressure on the result side: while the result register is full
// and stalled, the tick in the input register waits and in_stall is high. Modes
// are square, sawtooth, triangle, sine, half sine and an ECG pattern. The user
// must write mode and hold_us through the cfg port while idle (not enforced).
module multi_mode_waveform_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [wfg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wfg_pkg::HOLD_US_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wfg_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                          out_cycle_start
);
  import wfg_pkg::*;

  logic [MODE_W-1:0]    mode_r;
  logic [HOLD_US_W-1:0] hold_us_r;
  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  logic                 s1_restart_r;
  wfg_state_t           state_r;
  wfg_state_t           state_nxt;
  logic                 emit;
  wfg_result_t          res;
  logic                 can_load;
  logic                 advance;
  logic                 in_take;

  assign advance  = s1_valid_r && can_load;
  assign in_stall = s1_valid_r && !can_load;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_SQUARE;
      hold_us_r <= HOLD_US_W'(1000);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE: mode_r    <= cfg_wdata[MODE_W-1:0];
        REG_HOLD: hold_us_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      state_r    <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_restart_r <= in_restart;
    end
  end

  wfg_step u_step (
    .mode    (mode_r),
    .hold_us (hold_us_r),
    .restart (s1_restart_r),
    .cur     (state_r),
    .nxt     (state_nxt),
    .emit    (emit),
    .res     (res)
  );

  wfg_outbuf u_outbuf (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (advance && emit),
    .res             (res),
    .can_load        (can_load),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample      (out_sample),
    .out_cycle_start (out_cycle_start)
  );

  // A tick that only counts down the hold leaves one less to go.
  a_hold_count: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !s1_restart_r && state_r.hold_left != '0)
      |=> (state_r.hold_left == $past(state_r.hold_left) - HOLD_WIDTH'(1)))
    else $error("hold counter did not step down");

  // A restart always starts a period with a word of its own.
  a_restart_word: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_restart_r) |=> (out_valid && out_cycle_start))
    else $error("restart did not give a first-step word");

  // The input side only waits on a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && s1_valid_r))
    else $error("input stalled without output back-pressure");

  // The ECG segment counter never leaves the segment list.
  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(advance) && mode_r == MODE_ECG |-> state_r.segment < SEG_W'(ECG_SEGS))
    else $error("ECG segment out of range");

endmodule
